[design/tbm_pkg.sv]
// ----------------------------------------------------------------------------
// tbm_pkg
// Shared types and constants of the temporal band-pass magnifier.
// ----------------------------------------------------------------------------
package tbm_pkg;

	// channel counts and field widths
	localparam int unsigned CHANNELS  = 3;
	localparam int unsigned IDX_W     = 7;
	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned LP_W      = 20;
	localparam int unsigned COEF_W    = 16;
	localparam int unsigned GAIN_W    = 10;
	localparam int unsigned BOOST_W   = 31;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_HIGH = 2'd0,
		CFG_COEF_LOW  = 2'd1,
		CFG_GAIN      = 2'd2
	} tbm_cfg_idx_t;

	// reset values of the registers
	localparam logic [COEF_W-1:0] COEF_HIGH_RST = 16'd8738;
	localparam logic [COEF_W-1:0] COEF_LOW_RST  = 16'd7646;
	localparam logic [GAIN_W-1:0] GAIN_RST      = 10'd200;

	typedef logic [LP_W-1:0] tbm_lp_t;

	// one stored entry: fast and slow lowpass of every channel
	typedef struct packed {
		tbm_lp_t [CHANNELS-1:0] fast;
		tbm_lp_t [CHANNELS-1:0] slow;
	} tbm_state_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [COEF_W-1:0] coef_high;
		logic [COEF_W-1:0] coef_low;
		logic [GAIN_W-1:0] gain;
	} tbm_coef_t;

endpackage

[design/tbm_if.sv]
// ----------------------------------------------------------------------------
// tbm_if
// Valid/ready channels of the magnifier: pixel in, result out, register write.
// ----------------------------------------------------------------------------
interface tbm_pix_if;
	import tbm_pkg::*;
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    pixel_index;
	logic                load;
	logic [SAMPLE_W-1:0] sample_red;
	logic [SAMPLE_W-1:0] sample_green;
	logic [SAMPLE_W-1:0] sample_blue;

	modport source (output valid, pixel_index, load, sample_red, sample_green, sample_blue,
		input ready);
	modport sink (input valid, pixel_index, load, sample_red, sample_green, sample_blue,
		output ready);
endinterface

interface tbm_res_if;
	import tbm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [IDX_W-1:0]          out_index;
	logic signed [BOOST_W-1:0] boost_red;
	logic signed [BOOST_W-1:0] boost_green;
	logic signed [BOOST_W-1:0] boost_blue;

	modport source (output valid, out_index, boost_red, boost_green, boost_blue,
		input ready);
	modport sink (input valid, out_index, boost_red, boost_green, boost_blue,
		output ready);
endinterface

interface tbm_cfg_if;
	import tbm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/tbm_chan.sv]
// ----------------------------------------------------------------------------
// tbm_chan
// Datapath of one colour channel: fast and slow lowpass update, band
// difference and gain, over stages s1 to s3.
// ----------------------------------------------------------------------------
module tbm_chan
	import tbm_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic                      load_s1,
	input  tbm_lp_t                   x_s1,
	input  tbm_lp_t                   fast_s1,
	input  tbm_lp_t                   slow_s1,
	input  tbm_coef_t                 coefs,
	output tbm_lp_t                   fast_new_s2,
	output tbm_lp_t                   slow_new_s2,
	output logic signed [BOOST_W-1:0] boost_s3
);

	localparam int unsigned DIFF_W = LP_W + 1;
	localparam int unsigned PROD_W = COEF_W + 1 + DIFF_W;
	localparam int unsigned MUL_W  = GAIN_W + 1 + DIFF_W;

	logic signed [DIFF_W-1:0] fast_err;
	logic signed [DIFF_W-1:0] slow_err;
	logic signed [PROD_W-1:0] fast_prod_s2;
	logic signed [PROD_W-1:0] slow_prod_s2;
	logic                     load_s2;
	tbm_lp_t                  x_s2;
	tbm_lp_t                  fast_s2;
	tbm_lp_t                  slow_s2;
	logic signed [DIFF_W-1:0] band_s3;
	logic signed [MUL_W-1:0]  boost_full;

	// s1: error to the sample, scaled by the smoothing factor
	assign fast_err = $signed({1'b0, x_s1}) - $signed({1'b0, fast_s1});
	assign slow_err = $signed({1'b0, x_s1}) - $signed({1'b0, slow_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			fast_prod_s2 <= $signed({1'b0, coefs.coef_high}) * fast_err;
			slow_prod_s2 <= $signed({1'b0, coefs.coef_low}) * slow_err;
			load_s2      <= load_s1;
			x_s2         <= x_s1;
			fast_s2      <= fast_s1;
			slow_s2      <= slow_s1;
		end
	end

	// s2: floor of the product over 2^16 added in, or seeded from the sample
	assign fast_new_s2 = load_s2 ? x_s2 : fast_s2 + fast_prod_s2[LP_W+COEF_W-1:COEF_W];
	assign slow_new_s2 = load_s2 ? x_s2 : slow_s2 + slow_prod_s2[LP_W+COEF_W-1:COEF_W];

	always_ff @(posedge clk) begin
		if (en) begin
			band_s3 <= $signed({1'b0, fast_new_s2}) - $signed({1'b0, slow_new_s2});
		end
	end

	// s3: amplified band difference, always within 31 signed bits
	assign boost_full = $signed({1'b0, coefs.gain}) * band_s3;
	assign boost_s3   = boost_full[BOOST_W-1:0];

endmodule

[design/temporal_bandpass_magnifier_core.sv]
// ----------------------------------------------------------------------------
// temporal_bandpass_magnifier_core
// Per-pixel fast and slow IIR lowpass held in one state memory, band-pass
// result amplified by a gain, for a downsampled video grid.
// ----------------------------------------------------------------------------
// path: registers s1, s2, s3 and the output; throughput: one item per cycle
//   while the output is not stalled, set by the state memory's single read
//   and write per cycle; forwarding covers back-to-back items on one pixel
// reset clears the pipeline valids and loads the register defaults; the state
//   memory is not cleared and holds nothing useful until a pixel is loaded
module temporal_bandpass_magnifier_core
	import tbm_pkg::*;
#(
	parameter int unsigned GRID_WIDTH  = 10,
	parameter int unsigned GRID_HEIGHT = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	tbm_cfg_if.sink   cfg,
	tbm_pix_if.sink   pix,
	tbm_res_if.source res
);

	localparam int unsigned CELLS  = GRID_WIDTH * GRID_HEIGHT;
	localparam int unsigned DEPTH  = (CELLS > (1 << IDX_W)) ? (1 << IDX_W) : CELLS;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [12:0] CELLS_C = 13'(CELLS);

	// configuration registers
	tbm_coef_t coefs_q;

	// pipeline control and payload
	logic                      en;
	logic                      v_s1, v_s2, v_s3;
	logic                      grid_s1, grid_s2, grid_s3;
	logic                      load_s1, load_s2, load_s3;
	logic [IDX_W-1:0]          idx_s1, idx_s2, idx_s3;
	tbm_lp_t [CHANNELS-1:0]    x_s1;
	tbm_state_t                rd_q;
	tbm_state_t                old_s1;
	tbm_state_t                new_s2;
	tbm_state_t                wr_s3;
	logic                      fwd2, fwd3;
	logic                      wr_en;
	logic signed [BOOST_W-1:0] boost_s3 [CHANNELS];

	// output register
	logic                      out_v_q;
	logic [IDX_W-1:0]          out_idx_q;
	logic signed [BOOST_W-1:0] out_boost_q [CHANNELS];

	// state memory
	tbm_state_t mem [DEPTH];

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.coef_high <= COEF_HIGH_RST;
			coefs_q.coef_low  <= COEF_LOW_RST;
			coefs_q.gain      <= GAIN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_COEF_HIGH: coefs_q.coef_high <= cfg.data;
				CFG_COEF_LOW:  coefs_q.coef_low  <= cfg.data;
				CFG_GAIN:      coefs_q.gain      <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves while the output register can take an item
	assign en        = !out_v_q || res.ready;
	assign pix.ready = en;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= pix.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
		end
	end

	// s0 to s1: capture the item and read its entry
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= pix.pixel_index;
			load_s1 <= pix.load;
			grid_s1 <= {6'd0, pix.pixel_index} < CELLS_C;
			x_s1[0] <= {pix.sample_red, 8'd0};
			x_s1[1] <= {pix.sample_green, 8'd0};
			x_s1[2] <= {pix.sample_blue, 8'd0};
			rd_q    <= mem[pix.pixel_index[ADDR_W-1:0]];
		end
	end

	// s1: newest value of the entry, from s2, s3 or the memory
	assign fwd2 = v_s2 && grid_s2 && (idx_s2 == idx_s1);
	assign fwd3 = v_s3 && grid_s3 && (idx_s3 == idx_s1);

	always_comb begin
		if (fwd2) begin
			old_s1 = new_s2;
		end else if (fwd3) begin
			old_s1 = wr_s3;
		end else begin
			old_s1 = rd_q;
		end
	end

	// channel datapaths
	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		tbm_chan u_chan (
			.clk         (clk),
			.en          (en),
			.load_s1     (load_s1),
			.x_s1        (x_s1[c]),
			.fast_s1     (old_s1.fast[c]),
			.slow_s1     (old_s1.slow[c]),
			.coefs       (coefs_q),
			.fast_new_s2 (new_s2.fast[c]),
			.slow_new_s2 (new_s2.slow[c]),
			.boost_s3    (boost_s3[c])
		);
	end

	// control of s2 and s3
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2  <= idx_s1;
			load_s2 <= load_s1;
			grid_s2 <= grid_s1;
			idx_s3  <= idx_s2;
			load_s3 <= load_s2;
			grid_s3 <= grid_s2;
			wr_s3   <= new_s2;
		end
	end

	// s2: write back the updated entry
	assign wr_en = en && v_s2 && grid_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s2[ADDR_W-1:0]] <= new_s2;
		end
	end

	// s3 to output: zero for a load or an index off the grid
	always_ff @(posedge clk) begin
		if (en) begin
			out_idx_q <= idx_s3;
			for (int c = 0; c < CHANNELS; c++) begin
				out_boost_q[c] <= (load_s3 || !grid_s3) ? '0 : boost_s3[c];
			end
		end
	end

	assign res.valid       = out_v_q;
	assign res.out_index   = out_idx_q;
	assign res.boost_red   = out_boost_q[0];
	assign res.boost_green = out_boost_q[1];
	assign res.boost_blue  = out_boost_q[2];

	// an accepted item enters s1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> v_s1)
		else $error("accepted item missing from s1");

	// a load or an off-grid item gives an all-zero result
	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3 && (load_s3 || !grid_s3)) |=>
		(res.valid && res.boost_red == '0 && res.boost_green == '0 && res.boost_blue == '0))
		else $error("load or off-grid item gave a non-zero result");

	// the result carries the index of the item that left s3
	a_res_index: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3) |=> (res.out_index == $past(idx_s3)))
		else $error("result index does not follow s3");

	// no state write for an off-grid item
	a_no_offgrid_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({6'd0, idx_s2} < CELLS_C))
		else $error("state write outside the grid");

endmodule
